@@ hw/rtl/lpcg_pkg.sv @@
// lpcg_pkg: shared types, constants and colour tables of the LED pattern colour generator
// depends on nothing; used by lpcg_grad_chan and led_pattern_color_generator

package lpcg_pkg;

  // pattern selection codes
  typedef enum logic [3:0] {
    MODE_BLACK    = 4'd0,
    MODE_GRAY25   = 4'd1,
    MODE_GRAY50   = 4'd2,
    MODE_GRAY75   = 4'd3,
    MODE_WHITE    = 4'd4,
    MODE_RED      = 4'd5,
    MODE_GREEN    = 4'd6,
    MODE_BLUE     = 4'd7,
    MODE_GRADIENT = 4'd8,
    MODE_RING     = 4'd9,
    MODE_WIPE     = 4'd10
  } mode_t;

  // default ring and wipe length in LEDs
  localparam int SWEEP_LEDS_DEF = 24;

  // phase rate factors per channel, turn fraction * 2^40 per ms
  localparam logic [27:0] RATE_K_RED   = 28'd174992710;
  localparam logic [27:0] RATE_K_GREEN = 28'd64747303;
  localparam logic [27:0] RATE_K_BLUE  = 28'd19249198;
  localparam logic [27:0] RATE_K_WHITE = 28'd12249490;

  // phase step from one LED to the next
  localparam logic [23:0] LED_STEP = 24'd356024;

  // wipe period: six colours of one second each
  localparam int WIPE_MS     = 1000;
  localparam int WIPE_CYCLE  = 6 * WIPE_MS;
  localparam int WIPE_SHIFT  = 43;
  localparam logic [31:0] WIPE_RECIP = 32'((64'd1 << WIPE_SHIFT) / 64'(WIPE_CYCLE));

  // colour packed as {red, green, blue, white}
  typedef logic [31:0] colour_t;

  function automatic colour_t fixed_colour(input logic [2:0] code);
    colour_t c;
    case (code)
      3'd0:    c = 32'h00000000;
      3'd1:    c = 32'h40404040;
      3'd2:    c = 32'h80808080;
      3'd3:    c = 32'hC0C0C0C0;
      3'd4:    c = 32'hFFFFFFFF;
      3'd5:    c = 32'hFF000000;
      3'd6:    c = 32'h00FF0000;
      3'd7:    c = 32'h0000FF00;
      default: c = 32'h00000000;
    endcase
    return c;
  endfunction

  function automatic colour_t wipe_colour(input logic [2:0] sel);
    colour_t c;
    case (sel)
      3'd0:    c = 32'h0000FF00;
      3'd1:    c = 32'h00FFFF40;
      3'd2:    c = 32'h00FF0080;
      3'd3:    c = 32'hFFFF00FF;
      3'd4:    c = 32'hFF000080;
      3'd5:    c = 32'hFF00FF40;
      default: c = 32'h00000000;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/lpcg_grad_chan.sv @@
// lpcg_grad_chan: one gradient channel, time to phase, parabolic sine, clamped level
// depends on lpcg_pkg; four register stages, one item per cycle

module lpcg_grad_chan #(
  parameter logic [27:0] RATE_K = lpcg_pkg::RATE_K_RED
) (
  input  logic        clk,
  input  logic [30:0] t_i,
  input  logic [4:0]  led_i,
  output logic [7:0]  chan_o
);

  logic [23:0] phase_r;
  logic [4:0]  led_r;
  logic [23:0] mag_r;
  logic        neg_r;
  logic [15:0] m_r;
  logic        neg2_r;
  logic [7:0]  chan_r;

  logic [58:0] prod_nxt;
  logic [23:0] p_nxt;
  logic [23:0] yv_nxt;
  logic [23:0] mag_nxt;
  logic [44:0] sq_nxt;
  logic [16:0] sum_nxt;
  logic [8:0]  v_nxt;

  // time phase product
  assign prod_nxt = 59'(t_i) * 59'(RATE_K);

  // led offset, quarter turn shift and magnitude
  assign p_nxt   = phase_r + 24'(led_r * lpcg_pkg::LED_STEP);
  assign yv_nxt  = p_nxt + 24'h400000;
  assign mag_nxt = yv_nxt[23] ? (yv_nxt - 24'h800000) : (24'h800000 - yv_nxt);

  // parabola a * (half - a)
  assign sq_nxt = 45'(mag_r) * 45'(24'h800000 - mag_r);

  // offset to unsigned and clamp
  assign sum_nxt = neg2_r ? (17'd32768 + 17'(m_r)) : (17'd32768 - 17'(m_r));
  assign v_nxt   = sum_nxt[16:8];

  always_ff @(posedge clk) begin
    phase_r <= prod_nxt[39:16];
    led_r   <= led_i;
    mag_r   <= mag_nxt;
    neg_r   <= ~yv_nxt[23];
    m_r     <= sq_nxt[44:29];
    neg2_r  <= neg_r;
    chan_r  <= v_nxt[8] ? 8'hFF : v_nxt[7:0];
  end

  assign chan_o = chan_r;

endmodule

@@ hw/rtl/led_pattern_color_generator.sv @@
// led_pattern_color_generator: top level, pattern select, ring and wipe paths, output register
// depends on lpcg_pkg and lpcg_grad_chan
//
// Usage
//   An item (in_led_index, in_time_ms) is taken at a rising edge with start high and
//   busy low. busy is held low: the pipeline takes one item in every cycle.
//   Each result shows on out_red/out_green/out_blue/out_white for one cycle with
//   out_valid high; the receiver cannot stall, so no back-pressure exists.
//   Each item passes the input register, four channel stages and the output register
//   before out_valid rises. Throughput is one item per cycle, set by the
//   six register stages (input, four channel stages, output) that all advance each
//   cycle; the gradient multipliers and the wipe and ring reciprocal multipliers
//   each sit alone between registers.
//   cfg_we with cfg_wdata writes mode_r; write it only while the pipe is empty.
//   Synchronous reset (rst_n low) empties the pipe and sets the gradient pattern.
//   Codes above ten give black.

module led_pattern_color_generator #(
  parameter int SWEEP_LEDS = lpcg_pkg::SWEEP_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_led_index,
  input  logic [30:0] in_time_ms,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_white
);

  localparam int          SPAN       = 256 * SWEEP_LEDS;
  localparam int          RS_W       = $clog2(2 * SWEEP_LEDS);
  localparam logic [32:0] RING_RECIP = 33'((64'd1 << 32) / 64'(SWEEP_LEDS));

  logic [3:0] mode_r;

  logic        v0_r, v1_r, v2_r, v3_r, v4_r;
  logic [3:0]  mode0_r, mode1_r, mode2_r, mode3_r, mode4_r;
  logic [4:0]  led0_r, led1_r, led2_r, led3_r;
  logic [30:0] t0_r, t1_r;

  logic [18:0]     q6_r;
  logic [24:0]     qs_r;
  logic [24:0]     y1_r;
  logic [7:0]      lo1_r, lo2_r;
  logic [13:0]     r6_r;
  logic [RS_W-1:0] rs_r;
  logic [2:0]      j3_r;
  logic [9:0]      part3_r;
  logic [RS_W+7:0] f3_r;
  lpcg_pkg::colour_t wipe4_r;
  logic [7:0]      lvl4_r;

  logic       out_valid_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r, out_white_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lpcg_pkg::MODE_GRADIENT;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // valid bits travel with the items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v0_r        <= start & ~busy;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    led0_r  <= in_led_index;
    t0_r    <= in_time_ms;
    mode0_r <= mode_r;
  end

  // gradient channels; the ring reads LED 0 at a quarter of the time
  logic        ring0;
  logic [30:0] tg;
  logic [4:0]  lg;
  logic [7:0]  ch_red, ch_green, ch_blue, ch_white;

  assign ring0 = (mode0_r == lpcg_pkg::MODE_RING);
  assign tg    = ring0 ? {2'b00, t0_r[30:2]} : t0_r;
  assign lg    = ring0 ? 5'd0 : led0_r;

  lpcg_grad_chan #(.RATE_K(lpcg_pkg::RATE_K_RED)) u_red (
    .clk(clk), .t_i(tg), .led_i(lg), .chan_o(ch_red)
  );
  lpcg_grad_chan #(.RATE_K(lpcg_pkg::RATE_K_GREEN)) u_green (
    .clk(clk), .t_i(tg), .led_i(lg), .chan_o(ch_green)
  );
  lpcg_grad_chan #(.RATE_K(lpcg_pkg::RATE_K_BLUE)) u_blue (
    .clk(clk), .t_i(tg), .led_i(lg), .chan_o(ch_blue)
  );
  lpcg_grad_chan #(.RATE_K(lpcg_pkg::RATE_K_WHITE)) u_white (
    .clk(clk), .t_i(tg), .led_i(lg), .chan_o(ch_white)
  );

  // stage 1: reciprocal quotients for the wipe cycle and the ring span
  logic [32:0] tri_t;
  logic [61:0] p6_nxt;
  logic [57:0] ps_nxt;

  assign tri_t  = {2'b00, t0_r} + {1'b0, t0_r, 1'b0};
  assign p6_nxt = 62'(t0_r) * 62'(lpcg_pkg::WIPE_RECIP);
  assign ps_nxt = 58'(tri_t[32:8]) * 58'(RING_RECIP);

  always_ff @(posedge clk) begin
    q6_r    <= p6_nxt[61:43];
    qs_r    <= ps_nxt[56:32];
    y1_r    <= tri_t[32:8];
    lo1_r   <= tri_t[7:0];
    t1_r    <= t0_r;
    led1_r  <= led0_r;
    mode1_r <= mode0_r;
  end

  // stage 2: raw remainders, at most one divisor too large
  logic [31:0] r6_full;
  logic [25:0] rs_full;

  assign r6_full = 32'(t1_r) - 32'(q6_r) * 32'(lpcg_pkg::WIPE_CYCLE);
  assign rs_full = 26'(y1_r) - 26'(qs_r) * 26'(SWEEP_LEDS);

  always_ff @(posedge clk) begin
    r6_r    <= r6_full[13:0];
    rs_r    <= rs_full[RS_W-1:0];
    lo2_r   <= lo1_r;
    led2_r  <= led1_r;
    mode2_r <= mode1_r;
  end

  // stage 3: corrected remainders, wipe second and part, ring position
  logic [13:0]     r6c;
  logic [2:0]      j_nxt;
  logic [13:0]     part_full;
  logic [RS_W-1:0] rsc;

  always_comb begin
    r6c = (r6_r >= 14'(lpcg_pkg::WIPE_CYCLE)) ? (r6_r - 14'(lpcg_pkg::WIPE_CYCLE)) : r6_r;
    if (r6c >= 14'd5000) begin
      j_nxt = 3'd5;
    end else if (r6c >= 14'd4000) begin
      j_nxt = 3'd4;
    end else if (r6c >= 14'd3000) begin
      j_nxt = 3'd3;
    end else if (r6c >= 14'd2000) begin
      j_nxt = 3'd2;
    end else if (r6c >= 14'd1000) begin
      j_nxt = 3'd1;
    end else begin
      j_nxt = 3'd0;
    end
    part_full = r6c - 14'(j_nxt) * 14'(lpcg_pkg::WIPE_MS);
    rsc = (rs_r >= RS_W'(SWEEP_LEDS)) ? (rs_r - RS_W'(SWEEP_LEDS)) : rs_r;
  end

  always_ff @(posedge clk) begin
    j3_r    <= j_nxt;
    part3_r <= part_full[9:0];
    f3_r    <= {rsc, lo2_r};
    led3_r  <= led2_r;
    mode3_r <= mode2_r;
  end

  // stage 4: wipe colour and ring level
  function automatic logic [19:0] abs20(input logic signed [19:0] x);
    return x[19] ? 20'(-x) : 20'(x);
  endfunction

  logic [17:0]        sweep_x;
  logic [17:0]        led_k;
  logic [2:0]         j_next;
  logic [2:0]         wsel;
  logic signed [19:0] d, dp, dm;
  logic [19:0]        ad, adp, adm, dmin;
  logic [17:0]        dq;
  logic [7:0]         lvl_nxt;

  always_comb begin
    sweep_x = 18'(SWEEP_LEDS) * 18'(part3_r);
    led_k   = 18'(led3_r) * 18'(lpcg_pkg::WIPE_MS);
    j_next  = (j3_r == 3'd5) ? 3'd0 : (j3_r + 3'd1);
    wsel    = (led_k > sweep_x) ? j3_r : j_next;

    d    = signed'(20'({led3_r, 8'd0}) - 20'(f3_r));
    dp   = d + signed'(20'(SPAN));
    dm   = d - signed'(20'(SPAN));
    ad   = abs20(d);
    adp  = abs20(dp);
    adm  = abs20(dm);
    dmin = ad;
    if (adp < dmin) begin
      dmin = adp;
    end
    if (adm < dmin) begin
      dmin = adm;
    end
    dq      = dmin[19:2];
    lvl_nxt = (dq >= 18'd255) ? 8'd0 : (8'd255 - dq[7:0]);
  end

  always_ff @(posedge clk) begin
    wipe4_r <= lpcg_pkg::wipe_colour(wsel);
    lvl4_r  <= lvl_nxt;
    mode4_r <= mode3_r;
  end

  // stage 5: pattern select into the output register
  logic [15:0] rr, rg, rb, rw;
  lpcg_pkg::colour_t col_nxt;

  assign rr = 16'(ch_red) * 16'(lvl4_r);
  assign rg = 16'(ch_green) * 16'(lvl4_r);
  assign rb = 16'(ch_blue) * 16'(lvl4_r);
  assign rw = 16'(ch_white) * 16'(lvl4_r);

  always_comb begin
    case (mode4_r) inside
      [lpcg_pkg::MODE_BLACK:lpcg_pkg::MODE_BLUE]: col_nxt = lpcg_pkg::fixed_colour(mode4_r[2:0]);
      lpcg_pkg::MODE_GRADIENT: col_nxt = {ch_red, ch_green, ch_blue, ch_white};
      lpcg_pkg::MODE_RING:     col_nxt = {rr[15:8], rg[15:8], rb[15:8], rw[15:8]};
      lpcg_pkg::MODE_WIPE:     col_nxt = wipe4_r;
      default:                 col_nxt = 32'h00000000;
    endcase
  end

  always_ff @(posedge clk) begin
    out_red_r   <= col_nxt[31:24];
    out_green_r <= col_nxt[23:16];
    out_blue_r  <= col_nxt[15:8];
    out_white_r <= col_nxt[7:0];
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_white = out_white_r;

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##6 out_valid)
    else $error("item lost in pipeline");

  // no result without an item in the last stage
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v4_r))
    else $error("result without item");

  // ring red and white never brighter than their reference channels
  a_ring_dim: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && mode4_r == lpcg_pkg::MODE_RING) |=>
      (out_red <= $past(ch_red) && out_white <= $past(ch_white)))
    else $error("ring level above reference");

  // wipe white comes from the colour table
  a_wipe_white: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && mode4_r == lpcg_pkg::MODE_WIPE) |=>
      (out_white == 8'h00 || out_white == 8'h40 || out_white == 8'h80 || out_white == 8'hFF))
    else $error("wipe white off table");

endmodule
